### src/chc_pkg.sv
// Package for the column histogram centroid block: field widths, word types,
// controller states, command/status structs and width helper functions.
// No dependencies.
package chc_pkg;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int CNT_W      = 17;
  localparam int CW_W       = 7;
  localparam int NF_W       = 9;
  localparam int Q4_W       = 14;
  localparam int WID_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Columns at or past this limit are flagged as overflow
  localparam int MAX_COLUMNS = 1024;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_CELLS = 256;
  localparam int DEF_FRAC_BITS = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [Q4_W-1:0]  Q4_MAX  = '1;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FRAC = 2'd1;
  localparam logic [CW_W-1:0]      CW_RESET       = 7'd8;
  localparam logic [NF_W-1:0]      NF_RESET       = 9'd77;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [COL_W-1:0] column;
    logic             frame_end;
  } in_word_t;

  typedef struct packed {
    logic [Q4_W-1:0]  center_q4;
    logic [Q4_W-1:0]  deviation_q4;
    logic [WID_W-1:0] width_q4;
    logic             empty_frame;
    logic             column_overflow;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_DIV_PIX, ST_LOOKUP, ST_INCR,
    ST_PEAK, ST_THR, ST_SWEEP, ST_TEST,
    ST_MUL_SQ, ST_NN_LD, ST_MUL_NN, ST_X_LD, ST_MUL_X,
    ST_SQRT_LD, ST_SQRT, ST_DEV_LD, ST_DIV_DEV,
    ST_NC_LD, ST_MUL_NC, ST_CTR_LD, ST_DIV_CTR, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {DSEL_PIX, DSEL_DEV, DSEL_CTR} div_sel_t;
  typedef enum logic [1:0] {MSEL_SQ, MSEL_NN, MSEL_X, MSEL_NC} mul_sel_t;

  typedef struct packed {
    logic     clear_wr;
    logic     load_in;
    logic     div_load;
    div_sel_t div_sel;
    logic     div_step;
    logic     pix_lookup;
    logic     pix_incr;
    logic     peak_rd;
    logic     thr_load;
    logic     sweep_rd;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     save_p;
    logic     sqrt_load;
    logic     sqrt_step;
    logic     save_dev;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic pix_set;
    logic frame_end;
    logic ovf_hit;
    logic sum_zero;
    logic out_full;
  } status_t;

  // Width helpers
  function automatic int idx_w(input int cells);
    return $clog2(cells);
  endfunction

  function automatic int sum_w(input int cells);
    return CNT_W + idx_w(cells);
  endfunction

  function automatic int n_w(input int cells);
    return sum_w(cells) + idx_w(cells);
  endfunction

  function automatic int q_w(input int cells);
    return sum_w(cells) + 2 * idx_w(cells);
  endfunction

  function automatic int v_w(input int cells);
    return sum_w(cells) + q_w(cells);
  endfunction

  function automatic int x_w(input int cells, input int frac);
    return v_w(cells) + 2 * CW_W + 2 * frac + 2;
  endfunction

  function automatic int xe_w(input int cells, input int frac);
    return x_w(cells, frac) + (x_w(cells, frac) & 1);
  endfunction

  function automatic int root_w(input int cells, input int frac);
    return xe_w(cells, frac) >> 1;
  endfunction

  function automatic int div_w(input int cells, input int frac);
    int a;
    int b;
    int r;
    a = n_w(cells) + CW_W + frac + 1;
    b = root_w(cells, frac) + 2;
    r = (a > b) ? a : b;
    if (r < COL_W) r = COL_W;
    return r;
  endfunction

  function automatic int mb_w(input int cells);
    return n_w(cells);
  endfunction

  function automatic int step_w(input int cells, input int frac);
    int lim;
    lim = cells + 2;
    if (div_w(cells, frac) > lim) lim = div_w(cells, frac);
    if (mb_w(cells) > lim) lim = mb_w(cells);
    if (root_w(cells, frac) > lim) lim = root_w(cells, frac);
    return $clog2(lim + 1);
  endfunction

endpackage

### src/chc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/chc_ctrl.sv
// Controller for the column histogram centroid block: sequences pixel updates,
// the end-of-frame histogram sweeps and the shared multiply/sqrt/divide steps.
// Depends on chc_pkg.
module chc_ctrl #(
  parameter int MAX_CELLS = 256,
  parameter int FRAC_BITS = 4
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_stall,
  input  chc_pkg::status_t                                  status,
  output chc_pkg::cmd_t                                     cmd,
  output logic [chc_pkg::step_w(MAX_CELLS, FRAC_BITS)-1:0]  step
);

  import chc_pkg::*;

  localparam int STEP_W = step_w(MAX_CELLS, FRAC_BITS);
  localparam int D_W    = div_w(MAX_CELLS, FRAC_BITS);
  localparam int MB_W   = mb_w(MAX_CELLS);
  localparam int R_W    = root_w(MAX_CELLS, FRAC_BITS);

  localparam logic [STEP_W-1:0] CELLS_END  = STEP_W'(MAX_CELLS);
  localparam logic [STEP_W-1:0] LAST_CLEAR = STEP_W'(MAX_CELLS - 1);
  localparam logic [STEP_W-1:0] LAST_PEAK  = STEP_W'(MAX_CELLS);
  localparam logic [STEP_W-1:0] LAST_SWEEP = STEP_W'(MAX_CELLS + 2);
  localparam logic [STEP_W-1:0] LAST_PIX   = STEP_W'(COL_W - 1);
  localparam logic [STEP_W-1:0] LAST_DIV   = STEP_W'(D_W - 1);
  localparam logic [STEP_W-1:0] LAST_MUL   = STEP_W'(MB_W - 1);
  localparam logic [STEP_W-1:0] LAST_SQRT  = STEP_W'(R_W - 1);

  state_t            state, state_next;
  logic [STEP_W-1:0] step_next;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    step_next  = '0;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (step == LAST_CLEAR) state_next = ST_IDLE;
        else step_next = step + STEP_W'(1);
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.pix_set) begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = DSEL_PIX;
          state_next   = ST_DIV_PIX;
        end else if (status.frame_end) begin
          state_next = ST_PEAK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_PIX: begin
        cmd.div_step = 1'b1;
        if (step == LAST_PIX) state_next = ST_LOOKUP;
        else step_next = step + STEP_W'(1);
      end
      ST_LOOKUP: begin
        cmd.pix_lookup = 1'b1;
        if (!status.ovf_hit) state_next = ST_INCR;
        else if (status.frame_end) state_next = ST_PEAK;
        else state_next = ST_IDLE;
      end
      ST_INCR: begin
        cmd.pix_incr = 1'b1;
        state_next   = status.frame_end ? ST_PEAK : ST_IDLE;
      end
      // find the peak count
      ST_PEAK: begin
        cmd.peak_rd = (step < CELLS_END);
        if (step == LAST_PEAK) state_next = ST_THR;
        else step_next = step + STEP_W'(1);
      end
      ST_THR: begin
        cmd.thr_load = 1'b1;
        state_next   = ST_SWEEP;
      end
      // threshold, accumulate moments and clear cells
      ST_SWEEP: begin
        cmd.sweep_rd = (step < CELLS_END);
        if (step == LAST_SWEEP) state_next = ST_TEST;
        else step_next = step + STEP_W'(1);
      end
      ST_TEST: begin
        if (status.sum_zero) begin
          state_next = ST_EMIT;
        end else begin
          cmd.mul_load = 1'b1;
          cmd.mul_sel  = MSEL_SQ;
          state_next   = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        cmd.mul_step = 1'b1;
        if (step == LAST_MUL) state_next = ST_NN_LD;
        else step_next = step + STEP_W'(1);
      end
      ST_NN_LD: begin
        cmd.save_p   = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MSEL_NN;
        state_next   = ST_MUL_NN;
      end
      ST_MUL_NN: begin
        cmd.mul_step = 1'b1;
        if (step == LAST_MUL) state_next = ST_X_LD;
        else step_next = step + STEP_W'(1);
      end
      ST_X_LD: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MSEL_X;
        state_next   = ST_MUL_X;
      end
      ST_MUL_X: begin
        cmd.mul_step = 1'b1;
        if (step == LAST_MUL) state_next = ST_SQRT_LD;
        else step_next = step + STEP_W'(1);
      end
      ST_SQRT_LD: begin
        cmd.sqrt_load = 1'b1;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == LAST_SQRT) state_next = ST_DEV_LD;
        else step_next = step + STEP_W'(1);
      end
      ST_DEV_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DSEL_DEV;
        state_next   = ST_DIV_DEV;
      end
      ST_DIV_DEV: begin
        cmd.div_step = 1'b1;
        if (step == LAST_DIV) state_next = ST_NC_LD;
        else step_next = step + STEP_W'(1);
      end
      ST_NC_LD: begin
        cmd.save_dev = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MSEL_NC;
        state_next   = ST_MUL_NC;
      end
      ST_MUL_NC: begin
        cmd.mul_step = 1'b1;
        if (step == LAST_MUL) state_next = ST_CTR_LD;
        else step_next = step + STEP_W'(1);
      end
      ST_CTR_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DSEL_CTR;
        state_next   = ST_DIV_CTR;
      end
      ST_DIV_CTR: begin
        cmd.div_step = 1'b1;
        if (step == LAST_DIV) state_next = ST_EMIT;
        else step_next = step + STEP_W'(1);
      end
      ST_EMIT: begin
        if (!status.out_full) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/chc_dp.sv
// Datapath for the column histogram centroid block: config registers, cell
// store, sweep pipeline, shift-add multiplier, integer sqrt, restoring divider.
// Depends on chc_pkg and chc_ram.
module chc_dp #(
  parameter int MAX_CELLS = 256,
  parameter int FRAC_BITS = 4
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  input  logic [chc_pkg::CFG_IDX_W-1:0]                    cfg_index,
  input  logic [chc_pkg::CFG_DATA_W-1:0]                   cfg_data,
  input  chc_pkg::in_word_t                                in_word,
  output logic                                             out_valid,
  input  logic                                             out_stall,
  output chc_pkg::out_word_t                               out_word,
  input  chc_pkg::cmd_t                                    cmd,
  input  logic [chc_pkg::step_w(MAX_CELLS, FRAC_BITS)-1:0] step,
  output chc_pkg::status_t                                 status
);

  import chc_pkg::*;

  localparam int IDX_W  = idx_w(MAX_CELLS);
  localparam int S_W    = sum_w(MAX_CELLS);
  localparam int N_W    = n_w(MAX_CELLS);
  localparam int Q_W    = q_w(MAX_CELLS);
  localparam int V_W    = v_w(MAX_CELLS);
  localparam int X_W    = x_w(MAX_CELLS, FRAC_BITS);
  localparam int XE_W   = xe_w(MAX_CELLS, FRAC_BITS);
  localparam int R_W    = root_w(MAX_CELLS, FRAC_BITS);
  localparam int D_W    = div_w(MAX_CELLS, FRAC_BITS);
  localparam int MB_W   = mb_w(MAX_CELLS);
  localparam int RM_W   = S_W + 2;
  localparam int CSQ_W  = 2 * IDX_W;
  localparam int THR_W  = CNT_W + NF_W;
  localparam int SH_X   = 2 * FRAC_BITS + 2;

  // Configuration registers
  logic [CW_W-1:0]   cell_width;
  logic [NF_W-1:0]   noise_frac;
  logic [CW_W-1:0]   cw_eff;
  logic [2*CW_W-1:0] cw_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width <= CW_RESET;
      noise_frac <= NF_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CELL_WIDTH) cell_width <= cfg_data[CW_W-1:0];
      else if (cfg_index == REG_NOISE_FRAC) noise_frac <= cfg_data;
    end
  end

  assign cw_eff = (cell_width == '0) ? CW_W'(1) : cell_width;
  assign cw_sq  = cw_eff * cw_eff;

  // Input word latch
  logic             pix_set_q;
  logic [COL_W-1:0] col_q;
  logic             fend_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pix_set_q <= (in_word.pixel_value != '0);
      col_q     <= in_word.column;
      fend_q    <= in_word.frame_end;
    end
  end

  // Restoring divider, one quotient bit per step
  logic [D_W-1:0]  dvd, quo, dvd_init;
  logic [RM_W-1:0] rem, dsr, dsr_init, div_t;
  logic            div_ge;

  // Shift-add multiplier
  logic [X_W-1:0]  ma, acc;
  logic [MB_W-1:0] mb;
  logic [V_W-1:0]  p_sq;

  // Integer square root, two radicand bits per step
  logic [XE_W-1:0]  xr;
  logic [R_W+1:0]   srem, sq_t, sq_trial;
  logic [R_W-1:0]   root;
  logic             sq_ge;

  // Moment accumulators
  logic [S_W-1:0] s_acc;
  logic [N_W-1:0] n_acc;
  logic [Q_W-1:0] q_acc;

  always_comb begin
    case (cmd.div_sel)
      DSEL_PIX: begin
        dvd_init = D_W'(col_q) << (D_W - COL_W);
        dsr_init = RM_W'(cw_eff);
      end
      DSEL_DEV: begin
        dvd_init = D_W'(root) + D_W'(s_acc);
        dsr_init = RM_W'({s_acc, 1'b0});
      end
      DSEL_CTR: begin
        dvd_init = (D_W'(acc) << FRAC_BITS) + D_W'(s_acc >> 1);
        dsr_init = RM_W'(s_acc);
      end
      default: begin
        dvd_init = '0;
        dsr_init = RM_W'(1);
      end
    endcase
  end

  assign div_t  = {rem[RM_W-2:0], dvd[D_W-1]};
  assign div_ge = (div_t >= dsr);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd <= dvd_init;
      dsr <= dsr_init;
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      dvd <= dvd << 1;
      rem <= div_ge ? (div_t - dsr) : div_t;
      quo <= {quo[D_W-2:0], div_ge};
    end
  end

  logic [Q4_W-1:0] quo_sat;
  assign quo_sat = (quo > D_W'(Q4_MAX)) ? Q4_MAX : quo[Q4_W-1:0];

  // Cell store
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr, addr_q;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;
  logic             ovf_hit, ovf_seen;
  logic             v0, v1, v2, rv_q;
  logic [IDX_W-1:0] c0, c1;
  logic [CSQ_W-1:0] csq0, csq1;

  assign ovf_hit = (32'(col_q) >= MAX_COLUMNS) || (32'(quo[COL_W-1:0]) >= MAX_CELLS);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = quo[IDX_W-1:0];
    if (cmd.pix_lookup && !ovf_hit) begin
      ram_re = 1'b1;
    end else if (cmd.peak_rd || cmd.sweep_rd) begin
      ram_re    = 1'b1;
      ram_raddr = step[IDX_W-1:0];
    end
    ram_we    = 1'b0;
    ram_waddr = c0;
    ram_wdata = '0;
    if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = step[IDX_W-1:0];
    end else if (cmd.pix_incr) begin
      ram_we    = 1'b1;
      ram_waddr = addr_q;
      ram_wdata = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CNT_W'(1);
    end else if (v0) begin
      ram_we = 1'b1;
    end
  end

  chc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Pixel lookup and overflow flag
  always_ff @(posedge clk) begin
    if (cmd.pix_lookup) addr_q <= quo[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_seen <= 1'b0;
    end else if (cmd.emit) begin
      ovf_seen <= 1'b0;
    end else if (cmd.pix_lookup && ovf_hit) begin
      ovf_seen <= 1'b1;
    end
  end

  // Sweep control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rv_q <= 1'b0;
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else begin
      rv_q <= cmd.peak_rd;
      v0   <= cmd.sweep_rd;
      v1   <= v0;
      v2   <= v1;
    end
  end

  // Peak and noise threshold
  logic [CNT_W-1:0] peak;
  logic [THR_W-1:0] thr;
  logic             keep;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      peak <= '0;
    end else if (rv_q && (ram_rdata > peak)) begin
      peak <= ram_rdata;
    end
    if (cmd.thr_load) thr <= peak * noise_frac;
  end

  assign keep = (THR_W'({ram_rdata, 8'd0}) >= thr);

  // Sweep datapath: threshold, products, accumulate
  logic [CNT_W-1:0]       h1;
  logic [IDX_W+CNT_W-1:0] pn2;
  logic [CSQ_W+CNT_W-1:0] pq2;

  always_ff @(posedge clk) begin
    c0   <= step[IDX_W-1:0];
    csq0 <= step[IDX_W-1:0] * step[IDX_W-1:0];
    h1   <= keep ? ram_rdata : '0;
    c1   <= c0;
    csq1 <= csq0;
    pn2  <= c1 * h1;
    pq2  <= csq1 * h1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      s_acc <= '0;
      n_acc <= '0;
      q_acc <= '0;
    end else begin
      if (v1) s_acc <= s_acc + S_W'(h1);
      if (v2) begin
        n_acc <= n_acc + N_W'(pn2);
        q_acc <= q_acc + Q_W'(pq2);
      end
    end
  end

  // Multiplier: operand select, then one multiplier bit per step
  always_ff @(posedge clk) begin
    if (cmd.save_p) p_sq <= V_W'(acc);
    if (cmd.mul_load) begin
      acc <= '0;
      case (cmd.mul_sel)
        MSEL_SQ: begin
          ma <= X_W'(q_acc);
          mb <= MB_W'(s_acc);
        end
        MSEL_NN: begin
          ma <= X_W'(n_acc);
          mb <= MB_W'(n_acc);
        end
        MSEL_X: begin
          ma <= X_W'(p_sq - V_W'(acc));
          mb <= MB_W'(cw_sq);
        end
        MSEL_NC: begin
          ma <= X_W'(n_acc);
          mb <= MB_W'(cw_eff);
        end
        default: begin
          ma <= '0;
          mb <= '0;
        end
      endcase
    end else if (cmd.mul_step) begin
      if (mb[0]) acc <= acc + ma;
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

  // Square root of the scaled variance term
  assign sq_t     = {srem[R_W-1:0], xr[XE_W-1:XE_W-2]};
  assign sq_trial = {root, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      xr   <= XE_W'(acc) << SH_X;
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      xr   <= xr << 2;
      srem <= sq_ge ? (sq_t - sq_trial) : sq_t;
      root <= {root[R_W-2:0], sq_ge};
    end
  end

  // Deviation hold and result word
  logic [Q4_W-1:0] dev_q;
  logic            sum_zero;

  assign sum_zero = (s_acc == '0);

  always_ff @(posedge clk) begin
    if (cmd.save_dev) dev_q <= quo_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.center_q4       <= sum_zero ? '0 : quo_sat;
      out_word.deviation_q4    <= sum_zero ? '0 : dev_q;
      out_word.width_q4        <= sum_zero ? '0 : {dev_q, 1'b0};
      out_word.empty_frame     <= sum_zero;
      out_word.column_overflow <= ovf_seen;
    end
  end

  assign status.pix_set   = pix_set_q;
  assign status.frame_end = fend_q;
  assign status.ovf_hit   = ovf_hit;
  assign status.sum_zero  = sum_zero;
  assign status.out_full  = out_valid;

`ifndef SYNTH
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result word appeared without an emit");

  a_ovf_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !ovf_seen)
    else $error("overflow flag not cleared after frame");

  a_incr_follows_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_incr |-> ($past(cmd.pix_lookup) && !$past(ovf_hit)))
    else $error("cell increment without a valid lookup");

  a_write_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(v0 && (cmd.pix_incr || cmd.clear_wr)))
    else $error("sweep clear collides with another cell write");
`endif

endmodule

### src/column_histogram_centroid.sv
// Top level of the column histogram centroid block: ties controller and datapath
// (which holds the cell store) together. Depends on chc_pkg, chc_ctrl, chc_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | in_word: pixel_value, column, frame_end
//  out     | out_valid / out_stall| out_word: center, deviation, width, flags
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (cell_width, noise frac)
//
// A set pixel passes through the bit-serial column-to-cell divider and the cell
// read-modify-write; a pixel that is not set skips both. A frame-end word adds
// two sweeps of the cell store and, unless the kept sum is zero, four shift-add
// multiplies, the bit-pair square root and two restoring divides.
// After reset a clearing pass zeroes every cell of the cell store, with
// in_stall high; config writes are taken at any time.
// The result word is held in an output register, so a stalled result does not
// block the next frame's pixels.
module column_histogram_centroid #(
  parameter int MAX_CELLS = chc_pkg::DEF_MAX_CELLS,
  parameter int FRAC_BITS = chc_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  chc_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output chc_pkg::out_word_t             out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [chc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chc_pkg::CFG_DATA_W-1:0] cfg_data
);

  import chc_pkg::*;

  localparam int STEP_W = step_w(MAX_CELLS, FRAC_BITS);

  cmd_t              cmd;
  status_t           status;
  logic [STEP_W-1:0] step;

  chc_ctrl #(
    .MAX_CELLS (MAX_CELLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .step     (step)
  );

  chc_dp #(
    .MAX_CELLS (MAX_CELLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .step      (step),
    .status    (status)
  );

endmodule
